// ===== rtl/kmuf_pkg.sv =====
// kmuf_pkg: shared constants and types of the kruskal union-find core
// no dependencies; imported by every module of the core but kmuf_ram

package kmuf_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int ADDR_BITS    = $clog2(MAX_VERTICES);
   localparam int VERTEX_BITS  = 11;
   localparam int SIZE_BITS    = 11;
   localparam int WEIGHT_BITS  = 16;
   localparam int TOTAL_BITS   = 26;
   localparam int COUNT_BITS   = 10;

   localparam logic [VERTEX_BITS-1:0] VERTEX_LIMIT = VERTEX_BITS'(MAX_VERTICES);
   localparam logic [TOTAL_BITS-1:0]  TOTAL_MAX    = {TOTAL_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0]  COUNT_MAX    = {COUNT_BITS{1'b1}};

   // register byte addresses
   localparam logic [2:0] REG_VERTEX_COUNT = 3'd0;

   typedef struct packed {
      logic [VERTEX_BITS-1:0] vertex_a;
      logic [VERTEX_BITS-1:0] vertex_b;
      logic [WEIGHT_BITS-1:0] weight;
      logic                   last_edge;
   } edge_type;

   typedef struct packed {
      logic                  accepted;
      logic [TOTAL_BITS-1:0] total_weight;
      logic [COUNT_BITS-1:0] edges_taken;
      logic                  bad_vertex;
      logic                  graph_done;
   } result_type;

endpackage

// ===== rtl/kruskal_mst_union_find_core.sv =====
// Kruskal edge-acceptance core over a union-find store.
// Edges, sorted by nondecreasing weight, enter on the req_ stream; one result per
// edge leaves on the rsp_ stream; vertex_count is set over the csr_ apb port.
// A good edge runs two fully path-compressing finds; differing roots get a union by size.
// Each find walks the parent memory one entry per cycle and then rewrites the
// walked path one entry per cycle, so an edge's time grows with depth_a and
// depth_b, depth being the walk length to the root (at most about log2 of the
// vertex count); an edge with a bad vertex skips both finds.
// The single read port of the parent memory sets that pace.
// A result sits in an output register; the next edge is taken while it waits.
// If the receiver stalls with a result still held, the next result waits in the
// core and req_tready stays low until the register frees.
// Reset, and every transfer into the output register of an edge with tlast set,
// starts a clearing pass over all 1024 entries that rewrites both memories to
// singletons; req_tready stays low during it, register writes still work.
// depends on kmuf_pkg, kmuf_csr, kmuf_engine, kmuf_ram

module kruskal_mst_union_find_core
   import kmuf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // vertex_a[10:0], vertex_b[21:11], weight[37:22], zero pad
   input  logic        req_tlast,  // last_edge
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // accepted[0], total_weight[26:1], edges_taken[36:27],
                                   // bad_vertex[37], zero pad
   output logic        rsp_tlast,  // graph_done
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [VERTEX_BITS-1:0] limit;
   edge_type               in_edge;
   result_type             res;
   logic                   res_valid;
   logic                   res_take;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_ff, rsp_in;

   assign csr_pready = 1'b1;

   kmuf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .limit       (limit)
   );

   assign in_edge.vertex_a  = req_tdata[10:0];
   assign in_edge.vertex_b  = req_tdata[21:11];
   assign in_edge.weight    = req_tdata[37:22];
   assign in_edge.last_edge = req_tlast;

   kmuf_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_edge   (in_edge),
      .limit     (limit),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res       (res)
   );

   // output slot is free when empty or being drained this cycle
   assign res_take = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_take) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.bad_vertex, rsp_ff.edges_taken,
                        rsp_ff.total_weight, rsp_ff.accepted};
   assign rsp_tlast  = rsp_ff.graph_done;

   // an edge is never both joined and rejected as out of range
   a_acc_not_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_ff.accepted && rsp_ff.bad_vertex))
      else $error("accepted and bad_vertex both set");

   // a joined edge always shows a nonzero edge count
   a_acc_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_ff.accepted) |-> (rsp_ff.edges_taken != '0))
      else $error("accepted edge with zero count");

   // the core works one edge at a time
   a_one_edge: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second edge taken while busy");

endmodule

// ===== rtl/kmuf_ram.sv =====
// kmuf_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies

module kmuf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/kmuf_csr.sv =====
// kmuf_csr: apb register file holding vertex_count, clamps it for the range check
// depends on kmuf_pkg

module kmuf_csr
   import kmuf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [2:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic [VERTEX_BITS-1:0] limit
);

   logic [VERTEX_BITS-1:0] vertex_count_ff;
   logic [VERTEX_BITS-1:0] vertex_count_in;
   logic                   wr_hit;

   assign wr_hit = csr_psel && csr_penable && csr_pwrite && (csr_paddr == REG_VERTEX_COUNT);

   always_comb begin
      vertex_count_in = vertex_count_ff;
      if (wr_hit) begin
         vertex_count_in = csr_pwdata[VERTEX_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VERTEX_LIMIT;
      end else begin
         vertex_count_ff <= vertex_count_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == REG_VERTEX_COUNT) begin
         csr_prdata = {{(32-VERTEX_BITS){1'b0}}, vertex_count_ff};
      end
   end

   // counts above the store depth behave as the full depth
   assign limit = (vertex_count_ff > VERTEX_LIMIT) ? VERTEX_LIMIT : vertex_count_ff;

endmodule

// ===== rtl/kmuf_engine.sv =====
// kmuf_engine: union-find sequencer over parent and set-size memories
// depends on kmuf_pkg and kmuf_ram

module kmuf_engine
   import kmuf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  edge_type               in_edge,
   input  logic [VERTEX_BITS-1:0] limit,
   output logic                   res_valid,
   input  logic                   res_take,
   output result_type             res
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_WALK = 3'd2;
   localparam logic [2:0] S_COMP = 3'd3;
   localparam logic [2:0] S_SZA  = 3'd4;
   localparam logic [2:0] S_SZB  = 3'd5;
   localparam logic [2:0] S_FIN  = 3'd6;
   localparam logic [2:0] S_CLR  = 3'd7;

   logic [2:0]             state_ff, state_in;
   logic                   phase_ff, phase_in;
   logic [ADDR_BITS-1:0]   cur_ff, cur_in;
   logic [ADDR_BITS-1:0]   start_ff, start_in;
   logic [ADDR_BITS-1:0]   root_ff, root_in;
   logic [ADDR_BITS-1:0]   ra_ff, ra_in;
   logic [ADDR_BITS-1:0]   node_b_ff, node_b_in;
   logic [SIZE_BITS-1:0]   sa_ff, sa_in;
   logic [WEIGHT_BITS-1:0] weight_ff, weight_in;
   logic                   last_ff, last_in;
   logic                   bad_ff, bad_in;
   logic                   acc_ff, acc_in;
   logic [TOTAL_BITS-1:0]  total_ff, total_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [ADDR_BITS-1:0]   clr_ff, clr_in;

   logic                   par_we;
   logic [ADDR_BITS-1:0]   par_waddr, par_wdata, par_raddr, par_q;
   logic                   size_we;
   logic [ADDR_BITS-1:0]   size_waddr, size_raddr;
   logic [SIZE_BITS-1:0]   size_wdata, size_q, size_sum;
   logic                   in_bad;
   logic [TOTAL_BITS:0]    total_sum;

   kmuf_ram #(.WIDTH(ADDR_BITS), .DEPTH(MAX_VERTICES)) u_parent (
      .clock   (clock),
      .wr_en   (par_we),
      .wr_addr (par_waddr),
      .wr_data (par_wdata),
      .rd_addr (par_raddr),
      .rd_data (par_q)
   );

   kmuf_ram #(.WIDTH(SIZE_BITS), .DEPTH(MAX_VERTICES)) u_size (
      .clock   (clock),
      .wr_en   (size_we),
      .wr_addr (size_waddr),
      .wr_data (size_wdata),
      .rd_addr (size_raddr),
      .rd_data (size_q)
   );

   assign in_bad = (in_edge.vertex_a == '0) || (in_edge.vertex_b == '0) ||
                   (in_edge.vertex_a > limit) || (in_edge.vertex_b > limit);
   assign size_sum  = sa_ff + size_q;
   assign total_sum = {1'b0, total_ff} + {{(TOTAL_BITS+1-WEIGHT_BITS){1'b0}}, weight_ff};
   assign in_ready  = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_FIN);
   assign size_raddr = (state_ff == S_SZA) ? root_ff : ra_ff;

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      cur_in    = cur_ff;
      start_in  = start_ff;
      root_in   = root_ff;
      ra_in     = ra_ff;
      node_b_in = node_b_ff;
      sa_in     = sa_ff;
      weight_in = weight_ff;
      last_in   = last_ff;
      bad_in    = bad_ff;
      acc_in    = acc_ff;
      total_in  = total_ff;
      count_in  = count_ff;
      clr_in    = clr_ff;
      par_we     = 1'b0;
      par_waddr  = cur_ff;
      par_wdata  = root_ff;
      par_raddr  = cur_ff;
      size_we    = 1'b0;
      size_waddr = ra_ff;
      size_wdata = size_sum;

      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cur_in    = ADDR_BITS'(in_edge.vertex_a - 1'b1);
               start_in  = ADDR_BITS'(in_edge.vertex_a - 1'b1);
               node_b_in = ADDR_BITS'(in_edge.vertex_b - 1'b1);
               weight_in = in_edge.weight;
               last_in   = in_edge.last_edge;
               bad_in    = in_bad;
               acc_in    = 1'b0;
               phase_in  = 1'b0;
               state_in  = in_bad ? S_FIN : S_READ;
            end
         end
         S_READ: begin
            par_raddr = cur_ff;
            state_in  = S_WALK;
         end
         S_WALK: begin
            // root reached when the entry points to itself
            if (par_q == cur_ff) begin
               root_in   = cur_ff;
               cur_in    = start_ff;
               par_raddr = start_ff;
               state_in  = S_COMP;
            end else begin
               cur_in    = par_q;
               par_raddr = par_q;
            end
         end
         S_COMP: begin
            if (cur_ff != root_ff) begin
               // point this node at the root and follow its old parent
               par_we    = 1'b1;
               par_waddr = cur_ff;
               par_wdata = root_ff;
               cur_in    = par_q;
               par_raddr = par_q;
            end else if (!phase_ff) begin
               ra_in    = root_ff;
               phase_in = 1'b1;
               cur_in   = node_b_ff;
               start_in = node_b_ff;
               state_in = S_READ;
            end else if (root_ff == ra_ff) begin
               state_in = S_FIN;
            end else begin
               state_in = S_SZA;
            end
         end
         S_SZA: begin
            sa_in    = size_q;
            state_in = S_SZB;
         end
         S_SZB: begin
            par_we  = 1'b1;
            size_we = 1'b1;
            // union by size, ties go to the first vertex's root
            if (sa_ff >= size_q) begin
               par_waddr  = root_ff;
               par_wdata  = ra_ff;
               size_waddr = ra_ff;
            end else begin
               par_waddr  = ra_ff;
               par_wdata  = root_ff;
               size_waddr = root_ff;
            end
            acc_in   = 1'b1;
            total_in = total_sum[TOTAL_BITS] ? TOTAL_MAX : total_sum[TOTAL_BITS-1:0];
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + 1'b1;
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            if (res_take) begin
               if (last_ff) begin
                  total_in = '0;
                  count_in = '0;
                  clr_in   = '0;
                  state_in = S_CLR;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_CLR: begin
            par_we     = 1'b1;
            par_waddr  = clr_ff;
            par_wdata  = clr_ff;
            size_we    = 1'b1;
            size_waddr = clr_ff;
            size_wdata = SIZE_BITS'(1);
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == ADDR_BITS'(MAX_VERTICES - 1)) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff   <= '0;
         total_ff <= '0;
         count_ff <= '0;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         total_ff <= total_in;
         count_ff <= count_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      start_ff  <= start_in;
      root_ff   <= root_in;
      ra_ff     <= ra_in;
      node_b_ff <= node_b_in;
      sa_ff     <= sa_in;
      weight_ff <= weight_in;
      last_ff   <= last_in;
      bad_ff    <= bad_in;
      acc_ff    <= acc_in;
   end

   assign res.accepted     = acc_ff;
   assign res.total_weight = total_ff;
   assign res.edges_taken  = count_ff;
   assign res.bad_vertex   = bad_ff;
   assign res.graph_done   = last_ff;

endmodule
